// File: hw/rtl/b64c_pkg.sv
// Shared types, constants and alphabet functions for the base64 stream codec.
package b64c_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // One group's worth of results; bytes[0] goes out first.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            last;
    logic            bad;
  } b64c_cmd_t;

  typedef struct packed {
    logic       push;
    b64c_cmd_t  cmd;
  } b64c_push_t;

  typedef struct packed {
    logic       known;
    logic [5:0] val;
  } b64c_sym_t;

  function automatic logic [7:0] sym_of(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      r = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      r = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      r = 8'h2B;
    end else begin
      r = 8'h2F;
    end
    return r;
  endfunction

  function automatic b64c_sym_t val_of(input logic [7:0] c);
    b64c_sym_t r;
    r = '0;
    if (c inside {[8'h41:8'h5A]}) begin
      r.known = 1'b1;
      r.val   = 6'(c - 8'h41);
    end else if (c inside {[8'h61:8'h7A]}) begin
      r.known = 1'b1;
      r.val   = 6'(c - 8'h61 + 8'd26);
    end else if (c inside {[8'h30:8'h39]}) begin
      r.known = 1'b1;
      r.val   = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      r.known = 1'b1;
      r.val   = 6'd62;
    end else if (c == 8'h2F) begin
      r.known = 1'b1;
      r.val   = 6'd63;
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/b64c_front.sv
// Front end: mode register, group assembly and result command generation.
module b64c_front import b64c_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_mode,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       last_in,
  output b64c_push_t push_out
);

  logic        mode;
  logic [23:0] group_bits;
  logic [1:0]  group_count;
  logic [1:0]  pad_seen;
  logic        error_seen;

  logic [23:0] group_bits_next;
  logic [1:0]  group_count_next;
  logic [1:0]  pad_seen_next;
  logic        error_seen_next;

  logic [23:0] g;
  logic [23:0] ins;
  logic [5:0]  v;
  b64c_sym_t   sv;
  logic        is_pad;
  logic [1:0]  pad_upd;
  logic        err_upd;
  logic [2:0]  n;

  always_comb begin
    group_bits_next  = group_bits;
    group_count_next = group_count;
    pad_seen_next    = pad_seen;
    error_seen_next  = error_seen;
    push_out         = '0;
    g       = group_bits;
    ins     = '0;
    v       = '0;
    sv      = val_of(data_byte);
    is_pad  = (data_byte == PAD_CHAR);
    pad_upd = pad_seen;
    err_upd = error_seen;
    n       = {1'b0, group_count} + 3'd1;

    if (mode == MODE_ENCODE) begin
      case (group_count)
        2'd0:    ins = {data_byte, 16'h0};
        2'd1:    ins = {8'h0, data_byte, 8'h0};
        2'd2:    ins = {16'h0, data_byte};
        default: ins = '0;
      endcase
      g = group_bits | ins;
      if (group_count == 2'd2 || last_in) begin
        push_out.push           = 1'b1;
        push_out.cmd.bytes[0]   = sym_of(g[23:18]);
        push_out.cmd.bytes[1]   = sym_of(g[17:12]);
        push_out.cmd.bytes[2]   = (n >= 3'd2) ? sym_of(g[11:6]) : PAD_CHAR;
        push_out.cmd.bytes[3]   = (n >= 3'd3) ? sym_of(g[5:0]) : PAD_CHAR;
        push_out.cmd.last_idx   = 2'd3;
        push_out.cmd.last       = last_in;
        push_out.cmd.bad        = 1'b0;
        group_bits_next  = '0;
        group_count_next = '0;
        pad_seen_next    = '0;
        error_seen_next  = 1'b0;
      end else begin
        group_bits_next  = g;
        group_count_next = group_count + 2'd1;
      end
    end else begin
      if (is_pad) begin
        v = '0;
        if (group_count >= 2'd2) begin
          pad_upd = pad_seen + 2'd1;
        end else begin
          err_upd = 1'b1;
        end
      end else begin
        v = sv.known ? sv.val : 6'd0;
        if (!sv.known || pad_seen != 2'd0) begin
          err_upd = 1'b1;
        end
      end
      case (group_count)
        2'd0:    ins = {v, 18'h0};
        2'd1:    ins = {6'h0, v, 12'h0};
        2'd2:    ins = {12'h0, v, 6'h0};
        default: ins = {18'h0, v};
      endcase
      g = group_bits | ins;
      if (group_count != 2'd3) begin
        if (last_in) begin
          push_out.push         = 1'b1;
          push_out.cmd.last_idx = 2'd0;
          push_out.cmd.last     = 1'b1;
          push_out.cmd.bad      = 1'b1;
          group_bits_next  = '0;
          group_count_next = '0;
          pad_seen_next    = '0;
          error_seen_next  = 1'b0;
        end else begin
          group_bits_next  = g;
          group_count_next = group_count + 2'd1;
          pad_seen_next    = pad_upd;
          error_seen_next  = err_upd;
        end
      end else begin
        push_out.push         = 1'b1;
        push_out.cmd.bytes[0] = g[23:16];
        push_out.cmd.bytes[1] = g[15:8];
        push_out.cmd.bytes[2] = g[7:0];
        push_out.cmd.last_idx = 2'd2 - pad_upd;
        push_out.cmd.last     = last_in;
        push_out.cmd.bad      = err_upd;
        group_bits_next  = '0;
        group_count_next = '0;
        pad_seen_next    = '0;
        error_seen_next  = last_in ? 1'b0 : err_upd;
      end
    end

    if (!accept) begin
      push_out.push    = 1'b0;
      group_bits_next  = group_bits;
      group_count_next = group_count;
      pad_seen_next    = pad_seen;
      error_seen_next  = error_seen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_ENCODE;
      group_bits  <= '0;
      group_count <= '0;
      pad_seen    <= '0;
      error_seen  <= 1'b0;
    end else if (cfg_we) begin
      mode        <= cfg_mode;
      group_bits  <= '0;
      group_count <= '0;
      pad_seen    <= '0;
      error_seen  <= 1'b0;
    end else begin
      group_bits  <= group_bits_next;
      group_count <= group_count_next;
      pad_seen    <= pad_seen_next;
      error_seen  <= error_seen_next;
    end
  end

endmodule

// File: hw/rtl/b64c_queue.sv
// Command queue between the front end and the output sequencer.
module b64c_queue import b64c_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  b64c_push_t push_in,
  input  logic       pop,
  output b64c_cmd_t  head,
  output logic       empty,
  output logic       full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  b64c_cmd_t        slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CNT_W'(DEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_in.push) begin
      slots[wr_ptr] <= push_in.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_in.push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push_in.push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hw/rtl/b64c_back.sv
// Output sequencer: sends the results of each command, one per output transfer.
module b64c_back import b64c_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  b64c_cmd_t  head,
  input  logic       empty,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       bad_symbol
);

  b64c_cmd_t  cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       xfer;
  logic       done;

  assign xfer = cur_valid && !out_stall;
  assign done = xfer && (idx == cur.last_idx);
  assign pop  = !empty && (!cur_valid || done);

  assign out_valid  = cur_valid;
  assign out_byte   = cur.bytes[idx];
  assign out_last   = cur.last && (idx == cur.last_idx);
  assign bad_symbol = cur.bad;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (done) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (xfer) begin
      idx <= idx + 2'd1;
    end
  end

endmodule

// File: hw/rtl/base64_stream_codec_core.sv
// Top level of the base64 stream codec.
//
// Input channel: in_valid / in_stall with data_byte and last_in. An item is
// taken at an edge with in_valid high and in_stall low. last_in closes a
// message. Output channel: out_valid / out_stall with out_byte, out_last and
// bad_symbol, one result per transfer.
// Config channel: cfg_valid / cfg_ready with mode (0 encode, 1 decode). A write
// also drops any partly built group; write it only while the block is idle.
// A completing item writes its group's command into the queue, and the output
// sequencer then loads it. Input is taken one item per cycle while the queue
// has room; the sequencer sends one result per cycle unless out_stall is high,
// so encoding is output bound and decoding takes one symbol per cycle.
// Reset clears the mode to encode, the group state, the queue and the output.
// While out_stall is high the current result holds; the queue (QUEUE_DEPTH
// groups) keeps absorbing, and in_stall rises when it is full.
module base64_stream_codec_core import b64c_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       last_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       bad_symbol,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       mode
);

  b64c_push_t push;
  b64c_cmd_t  head;
  logic       empty;
  logic       full;
  logic       pop;
  logic       accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign accept    = in_valid && !full;

  b64c_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_mode  (mode),
    .accept    (accept),
    .data_byte (data_byte),
    .last_in   (last_in),
    .push_out  (push)
  );

  b64c_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push_in (push),
    .pop     (pop),
    .head    (head),
    .empty   (empty),
    .full    (full)
  );

  b64c_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .out_last   (out_last),
    .bad_symbol (bad_symbol)
  );

endmodule

// File: hw/rtl/b64c_checker.sv
// Port-level checks for the base64 stream codec, bound to the top level.
module b64c_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_last,
  input logic       bad_symbol
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) &&
      $stable(out_last) && $stable(bad_symbol))
    else $error("stalled output transfer changed");

  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("output or stall active after reset");

  a_full_pending: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  a_stall_drain: assert property (@(posedge clk) disable iff (rst)
    in_stall && !out_stall && out_valid && out_last |=> !in_stall)
    else $error("queue did not drain after final transfer");

endmodule

bind base64_stream_codec_core b64c_checker u_chk (.*);
